[hdl/yaz0_pkg.sv]
// Shared types and constants for the Yaz0 stream decompressor.
// No dependencies.
package yaz0_pkg;

    localparam int HISTORY_DEPTH_DEF = 4096;
    localparam int OUT_LANES_DEF     = 8;
    localparam int LANES_MAX         = 8;
    localparam int CMDQ_DEPTH        = 4;

    localparam logic [31:0] MAGIC_WORD = 32'h5961_7A30;
    localparam logic [8:0]  EXT_BIAS   = 9'h012;
    localparam logic [8:0]  NIB_BIAS   = 9'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
    localparam logic [1:0] ST_BAD_REF   = 2'd2;
    localparam logic [1:0] ST_TRUNC     = 2'd3;

    typedef enum logic [1:0] {
        K_NONE,
        K_LIT,
        K_COPY
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  lit;
        logic [12:0] distance;
        logic [8:0]  len;
        logic        done;
        logic        has_status;
        logic [1:0]  status;
    } t_cmd;

endpackage

[hdl/yaz0_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module yaz0_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hdl/yaz0_front.sv]
// Front end: header parse, code-bit tracking, copy length and error checks.
// Depends on yaz0_pkg; emits one command per input byte that yields results.
module yaz0_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_byte,
    input  logic          i_eoi,
    output logic          o_push,
    output yaz0_pkg::t_cmd o_cmd
);
    import yaz0_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER, PH_CODE, PH_LITERAL, PH_PAIR1, PH_PAIR2, PH_EXTLEN, PH_DONE, PH_ERROR
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_hidx, n_hidx;
    logic [31:0] r_total, n_total;
    logic [31:0] r_prod, n_prod;
    logic [7:0]  r_code, n_code;
    logic [3:0]  r_left, n_left;
    logic [7:0]  r_pf, n_pf;
    logic [7:0]  r_ps, n_ps;

    logic        active;
    logic        do_copy;
    logic        item_done;
    logic [8:0]  copy_len;
    logic [8:0]  len;
    logic [7:0]  second;
    logic [12:0] distance;
    logic [31:0] rem;
    t_cmd        cmd;

    assign active = (r_phase != PH_DONE) && (r_phase != PH_ERROR);

    always_comb begin
        n_phase   = r_phase;
        n_hidx    = r_hidx;
        n_total   = r_total;
        n_prod    = r_prod;
        n_code    = r_code;
        n_left    = r_left;
        n_pf      = r_pf;
        n_ps      = r_ps;
        do_copy   = 1'b0;
        item_done = 1'b0;
        copy_len  = '0;
        len       = '0;
        cmd       = '0;
        cmd.kind  = K_NONE;
        second    = (r_phase == PH_PAIR2) ? i_byte : r_ps;
        distance  = {1'b0, r_pf[3:0], second} + 13'd1;
        rem       = r_total - r_prod;

        case (r_phase)
            PH_HEADER: begin
                if (r_hidx < 4'd8) begin
                    n_total = {r_total[23:0], i_byte};
                end
                if (r_hidx == 4'd3) begin
                    if (n_total != MAGIC_WORD) begin
                        n_phase    = PH_ERROR;
                        cmd.status = ST_BAD_MAGIC;
                    end else begin
                        n_total = '0;
                    end
                end
                if (r_hidx == 4'd15) begin
                    n_left  = '0;
                    n_phase = (r_total == '0) ? PH_DONE : PH_CODE;
                end
                n_hidx = r_hidx + 4'd1;
            end
            PH_CODE: begin
                n_code  = i_byte;
                n_left  = 4'd8;
                n_phase = i_byte[7] ? PH_LITERAL : PH_PAIR1;
            end
            PH_LITERAL: begin
                cmd.kind  = K_LIT;
                cmd.lit   = i_byte;
                n_prod    = r_prod + 32'd1;
                item_done = 1'b1;
            end
            PH_PAIR1: begin
                n_pf    = i_byte;
                n_phase = PH_PAIR2;
            end
            PH_PAIR2: begin
                n_ps = i_byte;
                if (r_pf[7:4] == 4'd0) begin
                    n_phase = PH_EXTLEN;
                end else begin
                    do_copy  = 1'b1;
                    copy_len = {5'd0, r_pf[7:4]} + NIB_BIAS;
                end
            end
            PH_EXTLEN: begin
                do_copy  = 1'b1;
                copy_len = {1'b0, i_byte} + EXT_BIAS;
            end
            default: ;
        endcase

        if (do_copy) begin
            if (32'(distance) > r_prod) begin
                n_phase    = PH_ERROR;
                cmd.status = ST_BAD_REF;
            end else begin
                len          = (32'(copy_len) > rem) ? rem[8:0] : copy_len;
                cmd.kind     = K_COPY;
                cmd.distance = distance;
                cmd.len      = len;
                n_prod       = r_prod + 32'(len);
                item_done    = 1'b1;
            end
        end

        if (item_done) begin
            n_code = {r_code[6:0], 1'b0};
            n_left = (r_left != 4'd0) ? r_left - 4'd1 : 4'd0;
            if (n_prod == r_total) begin
                n_phase = PH_DONE;
            end else if (n_left == 4'd0) begin
                n_phase = PH_CODE;
            end else begin
                n_phase = n_code[7] ? PH_LITERAL : PH_PAIR1;
            end
        end

        if (i_eoi && n_phase != PH_DONE && n_phase != PH_ERROR) begin
            n_phase    = PH_ERROR;
            cmd.status = ST_TRUNC;
        end

        cmd.done       = (n_phase == PH_DONE);
        cmd.has_status = (n_phase == PH_ERROR) || (n_phase == PH_DONE && cmd.kind == K_NONE);
        if (n_phase != PH_ERROR) begin
            cmd.status = ST_OK;
        end
    end

    assign o_push = i_accept && active && (cmd.kind != K_NONE || cmd.has_status);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_hidx  <= '0;
            r_total <= '0;
            r_prod  <= '0;
            r_code  <= '0;
            r_left  <= '0;
            r_pf    <= '0;
            r_ps    <= '0;
        end else if (i_accept && active) begin
            r_phase <= n_phase;
            r_hidx  <= n_hidx;
            r_total <= n_total;
            r_prod  <= n_prod;
            r_code  <= n_code;
            r_left  <= n_left;
            r_pf    <= n_pf;
            r_ps    <= n_ps;
        end
    end
endmodule

[hdl/yaz0_cmdq.sv]
// Short command queue between front end and back end.
// Depends on yaz0_pkg.
module yaz0_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  yaz0_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output yaz0_pkg::t_cmd o_cmd
);
    import yaz0_pkg::*;

    localparam int PW = $clog2(CMDQ_DEPTH);

    t_cmd          r_q [CMDQ_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_q[r_wp] <= i_cmd;
                r_wp      <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end
endmodule

[hdl/yaz0_back.sv]
// Back end: history window writes, copy replay, packing and output register.
// Depends on yaz0_pkg and yaz0_ram.
module yaz0_back #(
    parameter int HISTORY_DEPTH = yaz0_pkg::HISTORY_DEPTH_DEF,
    parameter int OUT_LANES     = yaz0_pkg::OUT_LANES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  yaz0_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [63:0]    o_data_bytes,
    output logic [3:0]     o_byte_count,
    output logic           o_last,
    output logic           o_done_res,
    output logic [1:0]     o_status
);
    import yaz0_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_WR, S_EMIT, S_STAT
    } t_state;

    t_state      r_state;
    t_cmd        r_cmd;
    logic [AW-1:0] r_wp, r_src;
    logic [8:0]  r_rem;
    logic [7:0]  r_pack [LANES_MAX];
    logic [3:0]  r_cnt;
    logic        r_valid;
    logic [63:0] r_data;
    logic [3:0]  r_bcnt;
    logic        r_last, r_done;
    logic [1:0]  r_stat;

    logic          slot_free;
    logic          out_load;
    logic          we;
    logic [7:0]    wdata;
    logic [7:0]    rdata;
    logic [AW-1:0] wp_inc, src_inc;
    logic [AW:0]   src_calc;
    logic [63:0]   pack_flat;

    assign slot_free = !r_valid || i_ready;
    assign out_load  = slot_free && (r_state == S_EMIT || r_state == S_STAT);
    assign o_pop     = (r_state == S_IDLE) && !i_empty;
    assign we        = (o_pop && i_cmd.kind == K_LIT) || (r_state == S_WR);
    assign wdata     = (r_state == S_WR) ? rdata : i_cmd.lit;
    assign wp_inc    = (r_wp == AW'(HISTORY_DEPTH-1)) ? '0 : r_wp + 1'b1;
    assign src_inc   = (r_src == AW'(HISTORY_DEPTH-1)) ? '0 : r_src + 1'b1;
    assign src_calc  = ({1'b0, r_wp} >= (AW+1)'(i_cmd.distance))
                     ? {1'b0, r_wp} - (AW+1)'(i_cmd.distance)
                     : {1'b0, r_wp} + (AW+1)'(HISTORY_DEPTH) - (AW+1)'(i_cmd.distance);

    always_comb begin
        for (int i = 0; i < LANES_MAX; i++) begin
            pack_flat[8*i +: 8] = (4'(i) < r_cnt) ? r_pack[i] : 8'h00;
        end
    end

    yaz0_ram #(
        .WIDTH (8),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_wp),
        .i_wdata (wdata),
        .i_raddr (r_src),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wp    <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_valid <= 1'b1;
            end else if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_cmd <= i_cmd;
                        r_rem <= i_cmd.len;
                        r_src <= src_calc[AW-1:0];
                        case (i_cmd.kind)
                            K_LIT: begin
                                r_pack[0] <= i_cmd.lit;
                                r_cnt     <= 4'd1;
                                r_wp      <= wp_inc;
                                r_state   <= S_EMIT;
                            end
                            K_COPY:  r_state <= S_RD;
                            default: r_state <= S_STAT;
                        endcase
                    end
                end
                S_RD: begin
                    r_src   <= src_inc;
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_pack[r_cnt[2:0]] <= rdata;
                    r_cnt <= r_cnt + 4'd1;
                    r_rem <= r_rem - 9'd1;
                    r_wp  <= wp_inc;
                    if (r_cnt + 4'd1 == 4'(OUT_LANES) || r_rem == 9'd1) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_data  <= pack_flat;
                        r_bcnt  <= r_cnt;
                        r_last  <= (r_rem == '0) && !r_cmd.has_status;
                        r_done  <= (r_rem == '0) && r_cmd.done;
                        r_stat  <= ST_OK;
                        r_cnt   <= '0;
                        if (r_rem != '0) begin
                            r_state <= S_RD;
                        end else if (r_cmd.has_status) begin
                            r_state <= S_STAT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_STAT: begin
                    if (slot_free) begin
                        r_data  <= '0;
                        r_bcnt  <= '0;
                        r_last  <= 1'b1;
                        r_done  <= r_cmd.done;
                        r_stat  <= r_cmd.status;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_valid;
    assign o_data_bytes = r_data;
    assign o_byte_count = r_bcnt;
    assign o_last       = r_last;
    assign o_done_res   = r_done;
    assign o_status     = r_stat;
endmodule

[hdl/yaz0_stream_decompressor_core.sv]
// Top level of the Yaz0 stream decompressor: front end, command queue, back end.
// Depends on yaz0_pkg, yaz0_front, yaz0_cmdq, yaz0_back, yaz0_ram.
//
//   channel   handshake          payload
//   input     i_valid / o_ready  i_byte_in, i_end_of_input
//   output    o_valid / i_ready  o_data_bytes, o_byte_count, o_last, o_done_res, o_status
//
// Front end takes one byte per cycle while the 4-entry command queue has room.
// Back end: a literal is popped, then emitted; a copy is popped, then one history read and one
// write per byte, one emit per packed result; a status, if carried, is then sent on its own.
// Reset is synchronous, active low; history RAM is not cleared.
// Output register holds a result until taken; the back end stalls only when full.
module yaz0_stream_decompressor_core #(
    parameter int HISTORY_DEPTH = yaz0_pkg::HISTORY_DEPTH_DEF,
    parameter int OUT_LANES     = yaz0_pkg::OUT_LANES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte_in,
    input  logic        i_end_of_input,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_data_bytes,
    output logic [3:0]  o_byte_count,
    output logic        o_last,
    output logic        o_done_res,
    output logic [1:0]  o_status
);
    import yaz0_pkg::*;

    logic accept, push, pop, full, empty;
    t_cmd push_cmd, head_cmd;

    assign o_ready = !full;
    assign accept  = i_valid && !full;

    yaz0_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_byte_in),
        .i_eoi    (i_end_of_input),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    yaz0_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (head_cmd)
    );

    yaz0_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .OUT_LANES     (OUT_LANES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_cmd        (head_cmd),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_data_bytes (o_data_bytes),
        .o_byte_count (o_byte_count),
        .o_last       (o_last),
        .o_done_res   (o_done_res),
        .o_status     (o_status)
    );
endmodule

[hdl/yaz0_chk.sv]
// Port-level checker for the Yaz0 stream decompressor, bound to the top level.
// No package dependency.
module yaz0_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_data_bytes,
    input logic [3:0]  o_byte_count,
    input logic        o_last,
    input logic        o_done_res,
    input logic [1:0]  o_status
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data_bytes))
        else $error("output changed while stalled");

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_byte_count <= 4'd8)
        else $error("byte count out of range");

    a_stat_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_byte_count == 4'd0 |-> o_last && o_data_bytes == 64'd0)
        else $error("status transfer not final or not empty");

    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != 2'd0 |-> o_byte_count == 4'd0 && !o_done_res)
        else $error("error status with data or done");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res |-> o_last)
        else $error("done on non-final transfer");
endmodule

bind yaz0_stream_decompressor_core yaz0_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_data_bytes (o_data_bytes),
    .o_byte_count (o_byte_count),
    .o_last       (o_last),
    .o_done_res   (o_done_res),
    .o_status     (o_status)
);

[tb/sv/tb_top.sv]
// Self-checking testbench for yaz0_stream_decompressor_core.
// Feeds one Yaz0 stream (directed table, then random code groups) and checks every
// output transfer against an in-bench predictor; depends on yaz0_pkg and the RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import yaz0_pkg::*;

    localparam int HIST = 4096;
    localparam int LIMIT = 10000000;
    localparam int BODY_ITEMS = 340;

    typedef enum logic [2:0] {
        P_HDR, P_CODE, P_LIT, P_PAIR1, P_PAIR2, P_EXT, P_DONE, P_ERR
    } t_phase;

    typedef struct packed {
        logic [7:0] b;
        logic       eoi;
        logic       typed;
    } t_item;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  cnt;
        logic        last;
        logic        done;
        logic [1:0]  status;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_byte_in;
    logic        i_end_of_input;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_data_bytes;
    logic [3:0]  o_byte_count;
    logic        o_last;
    logic        o_done_res;
    logic [1:0]  o_status;

    yaz0_stream_decompressor_core dut (.*);

    // decoder state mirror
    logic [7:0]  hist [0:HIST-1];
    logic [11:0] wr_ptr;
    logic [31:0] produced;
    logic [31:0] out_size;
    t_phase      ph;
    logic [3:0]  hdr_idx;
    logic [7:0]  code_bits;
    logic [3:0]  bits_left;
    logic [7:0]  pair_hi;
    logic [7:0]  pair_lo;
    logic [7:0]  pend [0:287];
    int          npend;

    t_result     expected_q[$];
    t_item       stream_q[$];
    int          errors = 0;
    int          cycles = 0;
    int          stall_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if ((cycles / 3000) % 4 == 0 || r < 60) return 0;
        if (r < 96) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic void emit_byte(logic [7:0] b);
        hist[wr_ptr] = b;
        wr_ptr = wr_ptr + 1'b1;
        produced = produced + 1;
        pend[npend] = b;
        npend++;
    endfunction

    function automatic void next_element();
        code_bits = code_bits << 1;
        if (bits_left > 0) bits_left = bits_left - 1'b1;
        if (produced == out_size) ph = P_DONE;
        else if (bits_left == 0) ph = P_CODE;
        else ph = code_bits[7] ? P_LIT : P_PAIR1;
    endfunction

    function automatic void copy_back(int len, output logic [1:0] err);
        int distance;
        int n;
        logic [11:0] src;
        err = ST_OK;
        distance = {pair_hi[3:0], pair_lo} + 1;
        n = len;
        if (distance > produced) begin
            err = ST_BAD_REF;
            ph = P_ERR;
            return;
        end
        if (n > out_size - produced) n = out_size - produced;
        src = wr_ptr - distance[11:0];
        for (int i = 0; i < n; i++) begin
            emit_byte(hist[src]);
            src = src + 1'b1;
        end
        next_element();
    endfunction

    // Advance the decoder by one input byte; queue the results if keep is set.
    function automatic void decode_byte(logic [7:0] b, logic eoi, bit keep);
        logic [1:0] err;
        logic [31:0] cnt_so_far;
        t_result r;
        t_result res [$];
        int c;
        err = ST_OK;
        npend = 0;
        if (ph == P_DONE || ph == P_ERR) return;
        cnt_so_far = produced;
        case (ph)
            P_HDR: begin
                if (hdr_idx < 8) out_size = {out_size[23:0], b};
                if (hdr_idx == 3) begin
                    if (out_size != MAGIC_WORD) begin
                        err = ST_BAD_MAGIC;
                        ph = P_ERR;
                    end else begin
                        out_size = '0;
                    end
                end
                if (ph == P_HDR && hdr_idx == 15) begin
                    bits_left = 0;
                    ph = (out_size == 0) ? P_DONE : P_CODE;
                end
                hdr_idx = hdr_idx + 1'b1;
            end
            P_CODE: begin
                code_bits = b;
                bits_left = 8;
                ph = b[7] ? P_LIT : P_PAIR1;
            end
            P_LIT: begin
                emit_byte(b);
                next_element();
            end
            P_PAIR1: begin
                pair_hi = b;
                ph = P_PAIR2;
            end
            P_PAIR2: begin
                pair_lo = b;
                if (pair_hi[7:4] == 0) ph = P_EXT;
                else copy_back(pair_hi[7:4] + 2, err);
            end
            default: copy_back(b + 18, err);
        endcase
        if (eoi && ph != P_DONE && ph != P_ERR) begin
            err = ST_TRUNC;
            ph = P_ERR;
        end
        for (int i = 0; i < npend; i += 8) begin
            c = (npend - i > 8) ? 8 : npend - i;
            r = '0;
            for (int j = 0; j < c; j++) r.data[8*j +: 8] = pend[i + j];
            r.cnt = 4'(c);
            cnt_so_far = cnt_so_far + c;
            r.done = (cnt_so_far == out_size);
            res.push_back(r);
        end
        if (ph == P_ERR || (ph == P_DONE && npend == 0)) begin
            r = '0;
            r.done = (ph == P_DONE);
            r.status = (ph == P_ERR) ? err : ST_OK;
            res.push_back(r);
        end
        if (res.size() > 0) res[res.size() - 1].last = 1'b1;
        if (keep) foreach (res[i]) expected_q.push_back(res[i]);
    endfunction

    function automatic void add(logic [7:0] b, logic typed = 1'b0);
        stream_q.push_back('{b: b, eoi: 1'b0, typed: typed});
    endfunction

    // Build the whole compressed file: directed table, random groups, a closing element or an early end.
    function automatic void build_stream();
        int prod;
        int dmax;
        int d;
        int nib;
        int ext;
        int size;
        int scen;
        logic [7:0] code;
        logic [7:0] hdr [0:15];
        logic [7:0] lits [0:3];
        hdr = '{8'h59, 8'h61, 8'h7A, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF,
                8'hA5, 8'h5A, 8'h01, 8'h80, 8'h7F, 8'hFE};
        lits = '{8'h00, 8'hFF, 8'h80, 8'h7F};
        foreach (hdr[i]) add(hdr[i]);
        add(8'hF0);
        foreach (lits[i]) add(lits[i], 1'b1);
        // max nibble dist 1, min nibble dist 8, shortest and longest extended length
        add(8'hF0); add(8'h00);
        add(8'h10); add(8'h07);
        add(8'h00); add(8'h00); add(8'h00);
        add(8'h00); add(8'h05); add(8'hFF);
        prod = 4 + 17 + 3 + 18 + 273;

        while (stream_q.size() < BODY_ITEMS) begin
            code = 8'($urandom_range(0, 255));
            add(code);
            for (int k = 7; k >= 0; k--) begin
                if (code[k]) begin
                    add(8'($urandom_range(0, 255)));
                    prod++;
                end else begin
                    dmax = (prod < HIST) ? prod : HIST;
                    d = ($urandom_range(0, 3) == 0) ? $urandom_range(1, dmax)
                                                      : $urandom_range(1, 16);
                    d = d - 1;
                    if ($urandom_range(0, 9) < 7) begin
                        nib = $urandom_range(1, 15);
                        add({nib[3:0], d[11:8]}); add(d[7:0]);
                        prod += nib + 2;
                    end else begin
                        ext = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                          : $urandom_range(0, 15);
                        add({4'h0, d[11:8]}); add(d[7:0]); add(ext[7:0]);
                        prod += ext + 18;
                    end
                end
            end
        end

        scen = $urandom_range(0, 7);
        if ((scen == 1 || scen == 2) && prod >= HIST) scen = 5;
        if (scen == 1 || scen == 2) begin
            // reference reaching before the first byte
            add({1'b0, 7'($urandom_range(0, 127))});
            d = $urandom_range(prod, HIST - 1);
            nib = $urandom_range(0, 15);
            add({nib[3:0], d[11:8]}); add(d[7:0]);
            if (nib == 0) add(8'($urandom_range(0, 255)));
            size = prod + 5000;
        end else if (scen == 3 || scen == 4) begin
            size = prod + $urandom_range(1, 100000);
            stream_q[stream_q.size() - 1].eoi = 1'b1;
        end else begin
            // long copy cut short at the output size
            add({1'b0, 7'($urandom_range(0, 127))});
            d = $urandom_range(0, ((prod < HIST) ? prod : HIST) - 1);
            add({4'h0, d[11:8]}); add(d[7:0]); add(8'hFF);
            stream_q[stream_q.size() - 1].eoi = $urandom_range(0, 1);
            size = prod + $urandom_range(1, 272);
        end
        for (int i = 0; i < 4; i++) stream_q[4 + i].b = size[31 - 8*i -: 8];
        if (scen == 0) begin
            stream_q[$urandom_range(0, 3)].b ^= 8'(1 << $urandom_range(0, 7));
            foreach (stream_q[i]) stream_q[i].typed = 1'b0;
        end
        for (int i = 0; i < 5; i++)
            stream_q.push_back('{b: 8'($urandom_range(0, 255)), eoi: 1'($urandom_range(0, 1)),
                                 typed: 1'b0});
    endfunction

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else begin
            stall_left <= pick_gap();
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_data_bytes, o_byte_count, o_last, o_done_res, o_status};
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected transfer: %p", got);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    initial begin
        t_item it;
        t_result typed_res;
        int gap;
        int n;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_byte_in = '0;
        i_end_of_input = 1'b0;
        i_ready = 1'b0;
        wr_ptr = '0;
        produced = '0;
        out_size = '0;
        ph = P_HDR;
        hdr_idx = '0;
        code_bits = '0;
        bits_left = '0;
        pair_hi = '0;
        pair_lo = '0;
        build_stream();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        n = 0;
        while (stream_q.size() > 0) begin
            it = stream_q.pop_front();
            gap = pick_gap();
            if (n == 31 || n == 200) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (expected_q.size() > 0) @(posedge i_clk);
            end else if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid <= 1'b1;
            i_byte_in <= it.b;
            i_end_of_input <= it.eoi;
            do @(posedge i_clk); while (!o_ready);
            if (it.typed) begin
                typed_res = '{{56'h0, it.b}, 4'd1, 1'b1, 1'b0, ST_OK};
                expected_q.push_back(typed_res);
            end
            decode_byte(it.b, it.eoi, !it.typed);
            n++;
        end
        i_valid <= 1'b0;
        while (expected_q.size() > 0) @(posedge i_clk);
        repeat (1200) @(posedge i_clk);
        errors += expected_q.size();
        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

[yaz0_stream_decompressor_core.f]
hdl/yaz0_pkg.sv
hdl/yaz0_ram.sv
hdl/yaz0_front.sv
hdl/yaz0_cmdq.sv
hdl/yaz0_back.sv
hdl/yaz0_stream_decompressor_core.sv
hdl/yaz0_chk.sv
tb/sv/tb_top.sv
